@@ rtl/pbcm_pkg.sv @@
// Package for the pulsed BCM output table.
// Holds request/result structs, request and status codes, and the FSM state type.
// No dependencies.
package pbcm_pkg;

  // Request codes
  localparam logic [1:0] REQ_SET   = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Result kinds and status codes
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Pins per expander byte and pulse counter width
  localparam int unsigned PINS    = 8;
  localparam int unsigned PULSE_W = 15;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  channel;
    logic [2:0]  device;
    logic [2:0]  pin;
    logic [14:0] pulse_ms;
    logic [7:0]  high_level;
    logic [7:0]  low_level;
    logic [31:0] device_ok_mask;
  } req_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] out_channel;
    logic [6:0] out_address;
    logic [7:0] data_byte;
    logic       status;
    logic       last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FLUSH,
    ST_REPLY
  } state_t;

endpackage

@@ rtl/pbcm_advance.sv @@
// Pin countdown update for one table row: eight independent lanes.
// Depends on pbcm_pkg for pin count and counter width.
module pbcm_advance
  import pbcm_pkg::*;
#(
  parameter int unsigned PWM_BITS = 4
) (
  input  logic [PWM_BITS*8-1:0]     pattern_in,
  input  logic [PINS*PULSE_W-1:0]   pulse_in,
  input  logic [PINS*8-1:0]         level_in,
  input  logic [PWM_BITS-1:0]       dt,
  output logic [PWM_BITS*8-1:0]     pattern_out,
  output logic [PINS*PULSE_W-1:0]   pulse_out
);

  // Expire each armed countdown (loading its low level) or count it down
  always_comb begin
    logic [PULSE_W-1:0] r;
    pattern_out = pattern_in;
    pulse_out   = pulse_in;
    for (int p = 0; p < PINS; p++) begin
      r = pulse_in[p*PULSE_W +: PULSE_W];
      if (r != '0) begin
        if (r <= PULSE_W'(dt)) begin
          pulse_out[p*PULSE_W +: PULSE_W] = '0;
          for (int k = 0; k < PWM_BITS; k++) begin
            pattern_out[k*8 + p] = level_in[p*8 + k];
          end
        end else begin
          pulse_out[p*PULSE_W +: PULSE_W] = r - PULSE_W'(dt);
        end
      end
    end
  end

endmodule

@@ rtl/pulsed_bcm_output_table_unit.sv @@
// Pulsed BCM output table: one request in, zero or more results out.
// A scan visits each table entry with one memory read and then one check. A slot tick scans
// every entry and then passes through the flush state, which emits any pending write as last.
// A set_output scans entries up to the first hit or the last entry, then sends one status reply.
// Requests run one at a time; the next is taken in idle. Output stalls can hold ticks and replies.
// Results wait in an output register; clear_all clears every entry when accepted, staying idle.
// Synchronous active-high reset clears all entries, slot index and slot length; base address 32.
module pulsed_bcm_output_table_unit
  import pbcm_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES       = 32,
  parameter int unsigned PWM_BITS            = 4,
  parameter int unsigned DEVICES_PER_CHANNEL = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_t       req,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  localparam int unsigned IW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned SW    = (PWM_BITS > 1) ? $clog2(PWM_BITS) : 1;
  localparam int unsigned PAT_W = PWM_BITS * 8;
  localparam int unsigned PUL_W = PINS * PULSE_W;
  localparam int unsigned LVL_W = PINS * 8;
  localparam int unsigned ROW_W = 5 + PAT_W + PUL_W + LVL_W;

  state_t              state, state_next;
  req_t                req_q;
  logic [IW-1:0]       e;
  logic                pend_valid;
  res_t                pend;
  logic                reply_status;
  logic [SW-1:0]       slot_index;
  logic [PWM_BITS-1:0] last_slot_ms;
  logic [6:0]          base_addr;
  logic [TABLE_ENTRIES-1:0] entry_valid;

  logic [ROW_W-1:0] mem [TABLE_ENTRIES];
  logic [ROW_W-1:0] rdata;
  logic [ROW_W-1:0] wdata;

  logic [1:0]       rch;
  logic [2:0]       rdev;
  logic [PAT_W-1:0] rpat, adv_pat, pat_set;
  logic [PUL_W-1:0] rpul, adv_pul, pul_set;
  logic [LVL_W-1:0] rlvl, lvl_set;

  logic accept, out_free, is_set, fresh, hit, emit, stall, last_e, dev_ok;
  logic mem_rd, mem_we, out_load, pend_load, flush_go;
  res_t out_val, wr_res;

  assign req_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = req_valid && req_ready;
  assign out_free  = !res_valid || res_ready;

  // Unpack the row read from the table
  assign rch  = rdata[ROW_W-1 -: 2];
  assign rdev = rdata[ROW_W-3 -: 3];
  assign rpat = rdata[PUL_W+LVL_W +: PAT_W];
  assign rpul = rdata[LVL_W +: PUL_W];
  assign rlvl = rdata[0 +: LVL_W];

  assign is_set = (req_q.req_type == REQ_SET);
  assign fresh  = !entry_valid[e];
  assign hit    = fresh || (rch == req_q.channel && rdev == req_q.device);
  assign emit   = entry_valid[e] && (4'(rdev) < 4'(DEVICES_PER_CHANNEL))
                  && req_q.device_ok_mask[{rch, rdev}];
  assign stall  = !is_set && emit && pend_valid && !out_free;
  assign last_e = (e == IW'(TABLE_ENTRIES - 1));
  assign dev_ok = (4'(req.device) < 4'(DEVICES_PER_CHANNEL));

  pbcm_advance #(.PWM_BITS(PWM_BITS)) u_adv (
    .pattern_in  (rpat),
    .pulse_in    (rpul),
    .level_in    (rlvl),
    .dt          (last_slot_ms),
    .pattern_out (adv_pat),
    .pulse_out   (adv_pul)
  );

  // Build the row for a set_output hit
  always_comb begin
    pat_set = fresh ? '0 : rpat;
    pul_set = fresh ? '0 : rpul;
    lvl_set = fresh ? '0 : rlvl;
    for (int k = 0; k < PWM_BITS; k++) begin
      pat_set[k*8 + req_q.pin] = req_q.high_level[k];
    end
    pul_set[req_q.pin*PULSE_W +: PULSE_W] = req_q.pulse_ms;
    lvl_set[req_q.pin*8 +: 8]             = req_q.low_level;
  end

  // Bus write for the current entry
  always_comb begin
    wr_res             = '0;
    wr_res.kind        = KIND_WRITE;
    wr_res.out_channel = rch;
    wr_res.out_address = 7'(base_addr + 7'(rdev));
    wr_res.data_byte   = rpat[slot_index*8 +: 8];
    wr_res.status      = STATUS_OK;
    wr_res.last        = 1'b0;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.req_type)
            REQ_SET:  state_next = dev_ok ? ST_READ : ST_REPLY;
            REQ_TICK: state_next = ST_READ;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (is_set) begin
          state_next = (hit || last_e) ? ST_REPLY : ST_READ;
        end else if (!stall) begin
          state_next = last_e ? ST_FLUSH : ST_READ;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid || out_free) state_next = ST_IDLE;
      end
      ST_REPLY: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    mem_rd    = (state == ST_READ);
    mem_we    = 1'b0;
    wdata     = {rch, rdev, adv_pat, adv_pul, rlvl};
    out_load  = 1'b0;
    out_val   = pend;
    pend_load = 1'b0;
    flush_go  = 1'b0;
    case (state)
      ST_CHECK: begin
        if (is_set) begin
          mem_we = hit;
          wdata  = {req_q.channel, req_q.device, pat_set, pul_set, lvl_set};
        end else if (emit && !stall) begin
          mem_we    = 1'b1;
          pend_load = 1'b1;
          out_load  = pend_valid;
        end
      end
      ST_FLUSH: begin
        flush_go      = !pend_valid || out_free;
        out_load      = pend_valid && out_free;
        out_val.last  = 1'b1;
      end
      ST_REPLY: begin
        out_load       = out_free;
        out_val        = '0;
        out_val.kind   = KIND_STATUS;
        out_val.status = reply_status;
        out_val.last   = 1'b1;
      end
      default: ;
    endcase
  end

  // Table memory
  always_ff @(posedge clk) begin
    if (mem_rd) rdata <= mem[e];
    if (mem_we) mem[e] <= wdata;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      entry_valid  <= '0;
      pend_valid   <= 1'b0;
      res_valid    <= 1'b0;
      slot_index   <= '0;
      last_slot_ms <= '0;
      base_addr    <= 7'd32;
      e            <= '0;
      reply_status <= STATUS_OK;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) base_addr <= cfg_data;
      if (accept) begin
        e            <= '0;
        reply_status <= STATUS_FULL;
        if (req.req_type == REQ_CLEAR) entry_valid <= '0;
      end
      if (state == ST_CHECK) begin
        if (is_set && hit) begin
          entry_valid[e] <= 1'b1;
          reply_status   <= STATUS_OK;
        end
        if (!stall && !last_e && !(is_set && hit)) e <= e + 1'b1;
      end
      if (pend_load) pend_valid <= 1'b1;
      else if (flush_go) pend_valid <= 1'b0;
      if (flush_go) begin
        last_slot_ms <= PWM_BITS'(1) << slot_index;
        slot_index   <= (slot_index == SW'(PWM_BITS - 1)) ? '0 : slot_index + 1'b1;
      end
      if (out_load) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) req_q <= req;
    if (pend_load) pend <= wr_res;
    if (out_load) res <= out_val;
  end

`ifndef SYNTHESIS
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_valid) else $error("pending write left in idle");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && req.req_type == REQ_CLEAR |=> entry_valid == '0)
    else $error("clear_all left a valid entry");
  a_check_after_read: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> $past(state) == ST_READ || $past(state) == ST_CHECK)
    else $error("check without a memory read");
`endif

endmodule
